/* sv/orb_pkg.sv */
`default_nettype none

package orb_pkg;

	localparam int CAP_W = 13;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic        op;
		logic [7:0]  append_byte;
		logic [63:0] from_pos;
		logic [6:0]  byte_limit;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic        has_data;
		logic        last;
		logic [63:0] next_position;
	} rsp_t;

	typedef struct packed {
		logic append;
		logic load_req;
		logic calc_drop;
		logic calc_start;
		logic calc_check;
		logic calc_size;
		logic calc_next;
		logic issue;
		logic push_empty;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic last_issue;
		logic room;
	} dp_status_t;

endpackage

`default_nettype wire

/* sv/orb_ram.sv */
`default_nettype none

module orb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/orb_ctrl.sv */
`default_nettype none

module orb_ctrl import orb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic       req_op,
	output logic            req_ready,
	input  wire dp_status_t sts,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DROP   = 8'b0000_0010,
		ST_START  = 8'b0000_0100,
		ST_CHECK  = 8'b0000_1000,
		ST_SIZE   = 8'b0001_0000,
		ST_NEXT   = 8'b0010_0000,
		ST_STREAM = 8'b0100_0000,
		ST_EMPTY  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd            = '0;
		state_d        = state_q;
		cmd.append     = accept && (req_op == OP_APPEND);
		cmd.load_req   = accept && (req_op == OP_READ);
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_op == OP_READ)) begin
					state_d = ST_DROP;
				end
			end
			ST_DROP: begin
				cmd.calc_drop = 1'b1;
				state_d       = ST_START;
			end
			ST_START: begin
				cmd.calc_start = 1'b1;
				state_d        = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.calc_check = 1'b1;
				state_d        = ST_SIZE;
			end
			ST_SIZE: begin
				cmd.calc_size = 1'b1;
				state_d       = sts.empty ? ST_EMPTY : ST_NEXT;
			end
			ST_NEXT: begin
				cmd.calc_next = 1'b1;
				state_d       = ST_STREAM;
			end
			ST_STREAM: begin
				cmd.issue = sts.room;
				if (sts.room && sts.last_issue) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				cmd.push_empty = sts.room;
				if (sts.room) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* sv/orb_datapath.sv */
`default_nettype none

module orb_datapath import orb_pkg::*; #(
	parameter int DEPTH    = 4096,
	parameter int MAX_READ = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CAP_W-1:0] cfg_wr_data,
	input  wire req_t             req,
	input  wire ctrl_cmd_t        cmd,
	output dp_status_t            sts,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = $clog2(MAX_READ + 1);
	localparam int SW = (CW > CAP_W) ? CW : CAP_W;
	localparam int TW = (CW > LW) ? CW : LW;

	// Ring state
	logic [CW-1:0] cap_q;
	logic [AW-1:0] oldest_q;
	logic [CW-1:0] fill_q;
	logic [63:0]   produced_q;

	// Read request setup
	logic [63:0]   since_q;
	logic [LW-1:0] lim_q;
	logic [63:0]   dropped_q;
	logic [63:0]   start_q;
	logic          empty_q;
	logic [CW-1:0] offset_q;
	logic [LW-1:0] take_q;
	logic [AW-1:0] rd_ptr_q;
	logic [63:0]   next_q;
	logic [LW-1:0] remain_q;
	logic          inflight_q;
	logic          infl_last_q;

	// Two-entry result queue
	rsp_t          fifo_q [2];
	logic          wr_sel_q;
	logic          rd_sel_q;
	logic [1:0]    occ_q;

	logic [CW-1:0] cap_new;
	logic [CW:0]   wr_sum;
	logic [AW-1:0] wr_slot;
	logic          do_append;
	logic          full;
	logic [CW-1:0] oldest_inc;
	logic [CW-1:0] avail;
	logic [CW:0]   rd_sum;
	logic [CW-1:0] rd_inc;
	logic [7:0]    ram_rdata;
	logic          push;
	logic          pop;
	rsp_t          push_data;
	logic [1:0]    occ_after;

	assign cap_new = (SW'(cfg_wr_data) > SW'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_wr_data);

	// The write slot sits behind the newest byte; the sum stays below twice the capacity.
	assign wr_sum     = (CW+1)'(oldest_q) + (CW+1)'(fill_q);
	assign wr_slot    = (wr_sum >= (CW+1)'(cap_q)) ? AW'(wr_sum - (CW+1)'(cap_q)) : AW'(wr_sum);
	assign do_append  = cmd.append && (cap_q != '0);
	assign full       = (fill_q == cap_q);
	assign oldest_inc = CW'(oldest_q) + CW'(1);

	assign avail  = fill_q - offset_q;
	assign rd_sum = (CW+1)'(oldest_q) + (CW+1)'(offset_q);
	assign rd_inc = CW'(rd_ptr_q) + CW'(1);

	orb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (do_append),
		.waddr (wr_slot),
		.wdata (req.append_byte),
		.re    (cmd.issue),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= CW'(DEPTH);
			oldest_q   <= '0;
			fill_q     <= '0;
			produced_q <= '0;
		end else begin
			if (do_append) begin
				produced_q <= produced_q + 64'd1;
				if (full) begin
					oldest_q <= (oldest_inc == cap_q) ? '0 : AW'(oldest_inc);
				end else begin
					fill_q <= fill_q + CW'(1);
				end
			end
			// A new capacity empties the ring but keeps the produced count.
			if (cfg_wr_en) begin
				cap_q    <= cap_new;
				oldest_q <= '0;
				fill_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			since_q <= req.from_pos;
			lim_q   <= (req.byte_limit > 7'(MAX_READ)) ? LW'(MAX_READ) : LW'(req.byte_limit);
		end
		if (cmd.calc_drop) begin
			dropped_q <= produced_q - 64'(fill_q);
		end
		if (cmd.calc_start) begin
			start_q <= (since_q > dropped_q) ? since_q : dropped_q;
		end
		if (cmd.calc_check) begin
			empty_q  <= (start_q >= produced_q) || (lim_q == '0) || (cap_q == '0);
			offset_q <= CW'(start_q - dropped_q);
		end
		if (cmd.calc_size) begin
			take_q   <= (TW'(avail) < TW'(lim_q)) ? LW'(avail) : lim_q;
			rd_ptr_q <= (rd_sum >= (CW+1)'(cap_q)) ? AW'(rd_sum - (CW+1)'(cap_q))
			                                      : AW'(rd_sum);
		end
		if (cmd.calc_next) begin
			next_q <= start_q + 64'(take_q);
		end
		if (cmd.issue) begin
			rd_ptr_q    <= (rd_inc == cap_q) ? '0 : AW'(rd_inc);
			infl_last_q <= (remain_q == LW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q   <= '0;
			inflight_q <= 1'b0;
		end else begin
			inflight_q <= cmd.issue;
			if (cmd.calc_next) begin
				remain_q <= take_q;
			end else if (cmd.issue) begin
				remain_q <= remain_q - LW'(1);
			end
		end
	end

	// A fetch is started only when its byte is sure to find a free queue entry.
	assign pop       = rsp_valid && rsp_ready;
	assign push      = inflight_q || cmd.push_empty;
	assign occ_after = occ_q - {1'b0, pop};
	assign push_data = inflight_q ? rsp_t'{read_byte: ram_rdata, has_data: 1'b1,
	                                       last: infl_last_q, next_position: next_q}
	                              : rsp_t'{read_byte: 8'd0, has_data: 1'b0,
	                                       last: 1'b1, next_position: start_q};

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_sel_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_sel_q <= 1'b0;
			rd_sel_q <= 1'b0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_sel_q <= ~wr_sel_q;
			end
			if (pop) begin
				rd_sel_q <= ~rd_sel_q;
			end
			occ_q <= occ_after + {1'b0, push};
		end
	end

	assign rsp_valid      = (occ_q != '0);
	assign rsp            = fifo_q[rd_sel_q];
	assign sts.empty      = empty_q;
	assign sts.last_issue = (remain_q == LW'(1));
	assign sts.room       = ((occ_after + {1'b0, inflight_q}) < 2'd2);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && (occ_q == 2'd2) && !pop))
		else $error("result queue overflow");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q)
		else $error("fill count above capacity");

	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q == '0) || (CW'(oldest_q) < cap_q))
		else $error("oldest index outside ring");

	a_issue_remain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (remain_q != '0))
		else $error("fetch with nothing left to read");

	a_fetch_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> (push && !cmd.push_empty))
		else $error("fetched byte not queued");

endmodule

`default_nettype wire

/* sv/overwrite_ring_trace_buffer.sv */
`default_nettype none

// Byte trace ring that keeps the newest bytes of a stream. An append request
// is taken in the cycle it arrives while no read is in progress, so appends
// flow at one byte per cycle between reads. A read request steps through its
// 64-bit position arithmetic (oldest retained position, clamped start,
// availability check, size and start slot, next position) and then streams
// its bytes from the ring RAM at one per cycle while the output is taken;
// the next request waits until the last byte is fetched or an empty reply is
// queued. Replies leave through a two-entry result queue, so the next request
// is accepted while earlier results still wait. Write capacity only while the
// block is idle; doing so empties the ring.
module overwrite_ring_trace_buffer import orb_pkg::*; #(
	parameter int DEPTH    = 4096,
	parameter int MAX_READ = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CAP_W-1:0] cfg_wr_data,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp
);

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	orb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	orb_datapath #(
		.DEPTH    (DEPTH),
		.MAX_READ (MAX_READ)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Expected-reply store and byte-ring predictor for the trace buffer.
class trace_scoreboard;
	localparam int RING_DEPTH = 4096;
	localparam int READ_MAX   = 64;
	localparam int PRINT_MAX  = 50;

	logic [7:0]   ring_bytes [RING_DEPTH];
	int unsigned  head;
	int unsigned  fill;
	logic [63:0]  produced;
	int unsigned  capacity;
	orb_pkg::rsp_t replies [$];

	int errors;
	int appends_seen;
	int reads_seen;
	int empty_replies;
	int bytes_checked;

	function new();
		head = 0;
		fill = 0;
		produced = '0;
		capacity = RING_DEPTH;
		foreach (ring_bytes[i])
			ring_bytes[i] = '0;
	endfunction

	function void set_capacity(logic [orb_pkg::CAP_W-1:0] value);
		capacity = 32'(value);
		head = 0;
		fill = 0;
	endfunction

	function int unsigned live_capacity();
		return (capacity > RING_DEPTH) ? RING_DEPTH : capacity;
	endfunction

	function logic [63:0] oldest_position();
		return produced - 64'(fill);
	endfunction

	task report(string what);
		errors++;
		if (errors <= PRINT_MAX)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function void push_reply(logic [7:0] data, logic has, logic fin, logic [63:0] next_pos);
		orb_pkg::rsp_t r;
		r.read_byte = data;
		r.has_data = has;
		r.last = fin;
		r.next_position = next_pos;
		replies.push_back(r);
	endfunction

	function void note_request(orb_pkg::req_t r);
		int unsigned cap;
		int unsigned slot;
		int unsigned limit;
		logic [63:0] dropped;
		logic [63:0] start;
		logic [63:0] offset;
		logic [63:0] avail;
		logic [63:0] take;
		cap = live_capacity();
		if (r.op == orb_pkg::OP_APPEND) begin
			appends_seen++;
			// With no capacity the append leaves even the counter alone.
			if (cap == 0)
				return;
			produced++;
			if (fill > cap)
				fill = cap;
			slot = (head + fill) % cap;
			ring_bytes[slot] = r.append_byte;
			if (fill < cap)
				fill++;
			else
				head = (head + 1) % cap;
			return;
		end
		reads_seen++;
		limit = 32'(r.byte_limit);
		if (limit > READ_MAX)
			limit = READ_MAX;
		dropped = produced - 64'(fill);
		start = (r.from_pos > dropped) ? r.from_pos : dropped;
		if (start >= produced || limit == 0 || cap == 0) begin
			empty_replies++;
			push_reply(8'h00, 1'b0, 1'b1, start);
			return;
		end
		offset = start - dropped;
		avail = 64'(fill) - offset;
		take = (avail < 64'(limit)) ? avail : 64'(limit);
		for (int k = 0; k < take; k++) begin
			slot = 32'((64'(head) + offset + 64'(k)) % 64'(cap));
			push_reply(ring_bytes[slot], 1'b1, (64'(k) + 64'd1 == take), start + take);
		end
	endfunction

	task check_response(orb_pkg::rsp_t got);
		orb_pkg::rsp_t want;
		if (replies.size() == 0) begin
			report($sformatf("unexpected response %h", got));
			return;
		end
		want = replies.pop_front();
		bytes_checked++;
		if (got.read_byte !== want.read_byte)
			report($sformatf("read_byte %h, expected %h", got.read_byte, want.read_byte));
		if (got.has_data !== want.has_data)
			report($sformatf("has_data %b, expected %b", got.has_data, want.has_data));
		if (got.last !== want.last)
			report($sformatf("last %b, expected %b", got.last, want.last));
		if (got.next_position !== want.next_position)
			report($sformatf("next_position %h, expected %h",
				got.next_position, want.next_position));
	endtask
endclass

module testbench;
	import orb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CAP_W-1:0] cfg_wr_data;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_ready;
	rsp_t             rsp;

	trace_scoreboard sb;
	bit  calm;
	bit  hold_off;
	int  cycles;
	int  cap_settings;

	overwrite_ring_trace_buffer #(
		.DEPTH(4096),
		.MAX_READ(64)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycles, sb.replies.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int stall_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 25);
	endfunction

	// The receiver stalls on its own schedule; a pressure hold is counted here.
	initial begin
		rsp_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
				rsp_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				rsp_ready <= 1'b0;
				repeat (stall_len()) @(negedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	function automatic req_t append_req(logic [7:0] data);
		req_t r;
		r.op = OP_APPEND;
		r.append_byte = data;
		r.from_pos = {$urandom, $urandom};
		r.byte_limit = 7'($urandom);
		return r;
	endfunction

	function automatic req_t read_req(logic [63:0] since, logic [6:0] limit);
		req_t r;
		r.op = OP_READ;
		r.append_byte = 8'($urandom);
		r.from_pos = since;
		r.byte_limit = limit;
		return r;
	endfunction

	// Called at a falling edge; returns at a falling edge after acceptance.
	task automatic send_request(input req_t r);
		int gap;
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Appends give no reply, so a settling wait afterwards covers any that are still in flight.
	task automatic wait_idle(input int settle);
		req_valid <= 1'b0;
		while (sb.replies.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_idle(12);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_capacity(value);
		cap_settings++;
	endtask

	function automatic req_t random_read();
		logic [63:0] since;
		logic [6:0]  limit;
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			since = sb.oldest_position() + 64'($urandom_range(0, sb.fill));
		else if (r < 65)
			since = 64'($urandom_range(0, 32'(sb.oldest_position())));
		else if (r < 75)
			since = sb.produced + 64'($urandom_range(0, 5));
		else if (r < 85)
			since = {$urandom, $urandom};
		else
			since = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
		r = $urandom_range(0, 99);
		if (r < 70)
			limit = 7'($urandom_range(1, 64));
		else if (r < 80)
			limit = 7'd0;
		else
			limit = 7'($urandom_range(65, 127));
		return read_req(since, limit);
	endfunction

	task automatic random_phase(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 60) begin
				burst = $urandom_range(1, 12);
				for (int i = 0; i < burst && sent < count; i++) begin
					send_request(append_req(8'($urandom)));
					sent++;
				end
			end else begin
				send_request(random_read());
				sent++;
			end
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps [10];
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		hold_off = 1'b0;
		cycles = 0;
		cap_settings = 0;
		caps = '{13'd5, 13'd1, 13'd64, 13'd8191, 13'd17, 13'd0, 13'd300, 13'd2,
			13'd4096, 13'd33};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty ring, byte extremes, limit zero and saturation,
		// starts past the end and at the top of the counter.
		send_request(read_req(64'd0, 7'd64));
		send_request(append_req(8'h00));
		send_request(append_req(8'hFF));
		send_request(append_req(8'h5A));
		send_request(append_req(8'hA5));
		send_request(read_req(64'd0, 7'd64));
		send_request(read_req(64'd2, 7'd1));
		send_request(read_req(64'd0, 7'd0));
		send_request(read_req(64'd1, 7'd127));
		send_request(read_req(64'hFFFF_FFFF_FFFF_FFFF, 7'd10));
		send_request(read_req(64'd4, 7'd64));

		// Small ring overwritten; a read from zero is clamped up.
		write_capacity(13'd3);
		for (int i = 1; i <= 5; i++)
			send_request(append_req(8'(8'h11 * i)));
		send_request(read_req(64'd0, 7'd64));

		// Zero capacity ignores appends; an oversized setting saturates.
		write_capacity(13'd0);
		send_request(append_req(8'h77));
		send_request(read_req(64'd0, 7'd5));
		write_capacity(13'd8191);
		send_request(append_req(8'h99));
		send_request(read_req(64'd0, 7'd64));

		foreach (caps[p]) begin
			write_capacity(caps[p]);
			calm = (p == 3 || p == 7);
			if (caps[p] == 13'd64) begin
				// Append 40 bytes, then let the receiver hold off while reads pile up.
				for (int i = 0; i < 40; i++)
					send_request(append_req(8'($urandom)));
				hold_off = 1'b1;
				for (int i = 0; i < 8; i++)
					send_request(read_req(sb.oldest_position() +
						64'($urandom_range(0, 8)), 7'd64));
			end else begin
				random_phase(22);
			end
		end
		calm = 1'b0;

		wait_idle(30);
		if (sb.replies.size() != 0)
			sb.report($sformatf("%0d replies never arrived", sb.replies.size()));
		$display("Ran %0d appends and %0d reads over %0d capacity settings,",
			sb.appends_seen, sb.reads_seen, cap_settings);
		$display("checking %0d reply beats, %0d of them empty replies.",
			sb.bytes_checked, sb.empty_replies);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/orb_pkg.sv
sv/orb_ram.sv
sv/orb_ctrl.sv
sv/orb_datapath.sv
sv/overwrite_ring_trace_buffer.sv
tb/testbench.sv
